// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge while reset is released.
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_ALL(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("assertion failed");

`endif

// ===== rtl/css_pkg.sv =====
// Shared types and constants of the cocktail shaker sorter.
`timescale 1ns / 1ps

package css_pkg;

  // Width of one stored element.
  localparam int unsigned DataW = 32;

  // One signed element of the data set.
  typedef logic signed [DataW-1:0] data_t;

endpackage

// ===== rtl/css_mem.sv =====
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module css_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  css_pkg::data_t    wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output css_pkg::data_t    rdata_o
);

  css_pkg::data_t mem_q [DEPTH];
  css_pkg::data_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/css_engine.sv =====
// Load, sort and unload sequencer working on the element store.
`timescale 1ns / 1ps

module css_engine #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  css_pkg::data_t    value_i,
  input  logic              last_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output css_pkg::data_t    sorted_value_o,
  output logic              final_res_o,
  // Element store port.
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output css_pkg::data_t    mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  css_pkg::data_t    mem_rdata_i
);

  localparam int unsigned CntW = AW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_F_END,
    ST_BWD,
    ST_B_END,
    ST_OUT
  } state_e;

  state_e         state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AW-1:0]  lo_q, lo_d;
  logic [AW-1:0]  hi_q, hi_d;
  logic [AW-1:0]  ptr_q, ptr_d;
  logic [AW-1:0]  mark_q, mark_d;
  logic [AW-1:0]  didx_q;
  logic           rd_act_q, rd_act_d;
  logic           dv_q;
  logic           swapped_q, swapped_d;
  css_pkg::data_t carry_q, carry_d;

  logic            accept;
  logic            room;
  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] last_pos;
  logic            fwd_swap;
  logic            bwd_swap;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign room     = cnt_q < CntW'(DEPTH);
  assign cnt_inc  = cnt_q + (room ? CntW'(1) : CntW'(0));
  assign last_pos = cnt_q - CntW'(1);
  assign fwd_swap = carry_q > mem_rdata_i;
  assign bwd_swap = mem_rdata_i > carry_q;

  // Next state, read issue and write-back selection.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ptr_d       = ptr_q;
    mark_d      = mark_q;
    rd_act_d    = rd_act_q;
    swapped_d   = swapped_q;
    carry_d     = carry_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = carry_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;

    // Streaming reads: one address per cycle until the end of the sweep or of the unload.
    if (rd_act_q && (state_q == ST_FWD || state_q == ST_BWD || state_q == ST_OUT)) begin
      mem_re_o = 1'b1;
      case (state_q)
        ST_FWD: begin
          if (ptr_q == hi_q) rd_act_d = 1'b0;
          else ptr_d = ptr_q + AW'(1);
        end
        ST_BWD: begin
          if (ptr_q == lo_q) rd_act_d = 1'b0;
          else ptr_d = ptr_q - AW'(1);
        end
        default: begin
          if ({1'b0, ptr_q} == last_pos) rd_act_d = 1'b0;
          else ptr_d = ptr_q + AW'(1);
        end
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        // Load one item per accepted start; extra items are dropped.
        if (accept) begin
          mem_we_o    = room;
          mem_waddr_o = cnt_q[AW-1:0];
          mem_wdata_o = value_i;
          cnt_d       = cnt_inc;
          if (last_i) begin
            ptr_d    = '0;
            rd_act_d = 1'b1;
            if (cnt_inc >= CntW'(2)) begin
              lo_d      = '0;
              hi_d      = AW'(cnt_inc - CntW'(1));
              mark_d    = '0;
              swapped_d = 1'b0;
              state_d   = ST_FWD;
            end else begin
              state_d = ST_OUT;
            end
          end
        end
      end
      ST_FWD: begin
        // Carry the running maximum upward; write the smaller one behind it.
        if (dv_q) begin
          if (didx_q == lo_q) begin
            carry_d = mem_rdata_i;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = didx_q - AW'(1);
            mem_wdata_o = fwd_swap ? mem_rdata_i : carry_q;
            carry_d     = fwd_swap ? carry_q : mem_rdata_i;
            if (fwd_swap) begin
              swapped_d = 1'b1;
              mark_d    = didx_q - AW'(1);
            end
          end
          if (didx_q == hi_q) state_d = ST_F_END;
        end
      end
      ST_F_END: begin
        // Park the maximum at the top of the window, then sweep back or unload.
        mem_we_o    = 1'b1;
        mem_waddr_o = hi_q;
        if (!swapped_q || mark_q == lo_q) begin
          ptr_d    = '0;
          rd_act_d = 1'b1;
          state_d  = ST_OUT;
        end else begin
          hi_d     = mark_q;
          ptr_d    = mark_q;
          rd_act_d = 1'b1;
          state_d  = ST_BWD;
        end
      end
      ST_BWD: begin
        // Carry the running minimum downward; write the larger one behind it.
        if (dv_q) begin
          if (didx_q == hi_q) begin
            carry_d = mem_rdata_i;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = didx_q + AW'(1);
            mem_wdata_o = bwd_swap ? mem_rdata_i : carry_q;
            carry_d     = bwd_swap ? carry_q : mem_rdata_i;
            if (bwd_swap) mark_d = didx_q + AW'(1);
          end
          if (didx_q == lo_q) state_d = ST_B_END;
        end
      end
      ST_B_END: begin
        // Park the minimum at the bottom and shrink the window, then sweep forward or unload.
        mem_we_o    = 1'b1;
        mem_waddr_o = lo_q;
        lo_d        = mark_q;
        if (mark_q < hi_q) begin
          ptr_d     = mark_q;
          rd_act_d  = 1'b1;
          swapped_d = 1'b0;
          state_d   = ST_FWD;
        end else begin
          ptr_d    = '0;
          rd_act_d = 1'b1;
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        // Results leave straight from the read register.
        if (dv_q && ({1'b0, didx_q} == last_pos)) begin
          cnt_d   = '0;
          lo_d    = '0;
          hi_d    = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      ptr_q     <= '0;
      mark_q    <= '0;
      didx_q    <= '0;
      rd_act_q  <= 1'b0;
      dv_q      <= 1'b0;
      swapped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      ptr_q     <= ptr_d;
      mark_q    <= mark_d;
      didx_q    <= ptr_q;
      rd_act_q  <= rd_act_d;
      dv_q      <= mem_re_o;
      swapped_q <= swapped_d;
    end
  end

  // The carried element is payload and needs no reset.
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = dv_q && (state_q == ST_OUT);
  assign sorted_value_o = mem_rdata_i;
  assign final_res_o    = result_valid_o && ({1'b0, didx_q} == last_pos);

endmodule

// ===== rtl/cocktail_shaker_sorter.sv =====
// Top level of the cocktail shaker sorter: sequencer plus element store.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------
//   input    | start_i, busy_o           | value_i, last_i
//   result   | result_valid_o (strobe)   | sorted_value_o, final_res_o
//
// Loading takes one item per cycle. After the item marked last, the set is
// sorted by forward and backward sweeps over a shrinking window, whose pace
// is set by the single read port and single write port of the element store.
// Unloading gives the n elements back in order, one result a cycle.
// Reset clears the control state only; the store holds no valid bits.
// busy_o stays high from the last item until the final result has left.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cocktail_shaker_sorter #(
  parameter int unsigned DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  css_pkg::data_t value_i,
  input  logic           last_i,
  output logic           result_valid_o,
  output css_pkg::data_t sorted_value_o,
  output logic           final_res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  css_pkg::data_t mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  css_pkg::data_t mem_rdata;

  // Sequencer for load, sort sweeps and unload.
  css_engine #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .value_i        (value_i),
    .last_i         (last_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .sorted_value_o (sorted_value_o),
    .final_res_o    (final_res_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // Element store.
  css_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Results only appear while the block is busy with a set.
  `ASSERT_ALL(a_result_when_busy, result_valid_o |-> busy_o)
  // The final flag only rides on a result.
  `ASSERT_ALL(a_final_with_result, final_res_o |-> result_valid_o)
  // An accepted last item starts sorting or unloading.
  `ASSERT_RST(a_last_starts, (start_i && !busy_o && last_i) |=> busy_o)
  // The final result frees the block for the next set.
  `ASSERT_RST(a_final_frees, (result_valid_o && final_res_o) |=> !busy_o)

endmodule
